FILE: sv/fps_pkg.sv
// Shared types and constants for the funnel path straightener.
package fps_pkg;

    // Width of one coordinate field on the stream ports.
    localparam int FIELD_W = 32;
    // Corner pull ratio: Q1.16, one is 2^16.
    localparam int RATIO_W   = 17;
    localparam int FRAC_BITS = 16;
    localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;
    localparam int HALF_LSB  = 32768;
    // Output points kept per path.
    localparam int OUT_CNT_W = 7;
    localparam logic [OUT_CNT_W-1:0] OUT_LIMIT = 7'd64;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_START,
        ST_INIT,
        ST_NEXT,
        ST_FETCH,
        ST_XSET,
        ST_XRUN,
        ST_XDEC,
        ST_BLEND,
        ST_EMIT,
        ST_RST,
        ST_REOPEN,
        ST_GOAL,
        ST_FIN
    } fps_state_t;

    // Which side test is running.
    typedef enum logic [1:0] {
        T_R1,   // new right vs. funnel right
        T_R2,   // new right vs. funnel left
        T_L1,   // new left vs. funnel left
        T_L2    // new left vs. funnel right
    } fps_test_t;

endpackage

FILE: sv/funnel_path_straightener_top.sv
// Funnel path straightener: portal store plus sequential funnel scan.
//
// Usage. Portals arrive on the s_ slave stream, one transaction per portal
// (left point, right point; x,y,z each Q16.16). The first and the final
// portal carry start and goal as equal left/right points; s_tlast marks the
// goal portal. Loading takes one cycle per portal. After tlast the block
// stops taking portals and runs the funnel over the portal RAM, then streams
// the path points on the m_ master stream; m_tlast marks the final point and
// m_tuser flags a corridor that overflowed the store (extra portals dropped).
// Each scanned portal takes a RAM read and then 2 to 4 side tests (one
// shared 2-pass multiplier feeding an accumulator, four partial products
// per cross product). A corner is blended on one multiplier, one axis per
// cycle, then emitted, and the funnel is reopened from the RAM (ST_RST,
// ST_REOPEN) before the scan resumes. Points pass through a one-deep hold
// stage and an output register; a stalled receiver stalls the scan only
// when both are full. Reset returns the block to loading with an empty
// store; the store itself needs no clearing pass. cfg_we writes the corner
// pull ratio (Q1.16, values above one act as one); write it only while idle.
module funnel_path_straightener_top
    import fps_pkg::*;
#(
    parameter int MAX_PORTALS = 64,
    parameter int COORD_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // slave stream: portals
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: left_x, left_y, left_z, right_x, right_y, right_z (32 bits each)
    input  logic [6*FIELD_W-1:0] s_tdata,
    input  logic                 s_tlast,    // last_portal
    // master stream: path points
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: point_x, point_y, point_z (32 bits each)
    output logic [3*FIELD_W-1:0] m_tdata,
    output logic                 m_tlast,    // last_point
    output logic                 m_tuser,    // overflow
    // configuration: corner_offset_ratio
    input  logic                 cfg_we,
    input  logic [RATIO_W-1:0]   cfg_wdata
);

    localparam int CW   = COORD_WIDTH;
    localparam int SW   = (MAX_PORTALS > 1) ? $clog2(MAX_PORTALS) : 1;
    localparam int CNTW = $clog2(MAX_PORTALS + 1);
    localparam int DW   = CW + 1;          // coordinate difference
    localparam int LO   = DW / 2;          // low split of the multiplier operand
    localparam int PBW  = LO + 1;          // signed width of either split
    localparam int PW   = DW + PBW;        // partial product
    localparam int AW   = 2 * DW + 1;      // cross product accumulator
    localparam int BW   = DW + RATIO_W + 1; // blend product
    localparam int RAMW = 6 * CW;

    typedef logic [2:0][CW-1:0] pt_t;     // [0]=x [1]=y [2]=z

    // ------------------------------------------------------------------
    // registers
    fps_state_t state_reg, state_next, ret_reg;
    fps_test_t  tst_reg;
    logic [CNTW-1:0] count_reg, scan_reg;
    logic [SW-1:0]   lslot_reg, rslot_reg, rs_reg;
    logic            ovf_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [2:0]      cs_reg;
    logic [1:0]      bs_reg;
    logic [OUT_CNT_W-1:0] ocnt_reg;
    logic            pend_valid_reg;
    logic            out_valid_reg;

    pt_t apex_reg, fl_reg, fr_reg, fl_opp_reg, fr_opp_reg;
    pt_t nl_reg, nr_reg, last_left_reg, last_emit_reg;
    pt_t emit_pt_reg, pend_reg, out_pt_reg, bp_reg, bq_reg;
    logic            out_last_reg, out_ovf_reg;
    logic signed [DW-1:0] abx_reg, abz_reg, acx_reg, acz_reg;
    logic signed [AW-1:0] acc_reg, xprod_reg;
    logic                 xsub_reg;
    logic signed [BW-1:0] bprod_reg;

    // ------------------------------------------------------------------
    // portal RAM
    logic            ram_we;
    logic [SW-1:0]   ram_raddr;
    logic [RAMW-1:0] ram_rdata;
    pt_t             in_left, in_right, rd_left, rd_right;

    assign in_left  = {s_tdata[2*FIELD_W +: CW], s_tdata[FIELD_W +: CW], s_tdata[0 +: CW]};
    assign in_right = {s_tdata[5*FIELD_W +: CW], s_tdata[4*FIELD_W +: CW],
                       s_tdata[3*FIELD_W +: CW]};
    assign rd_left  = ram_rdata[3*CW-1:0];
    assign rd_right = ram_rdata[6*CW-1:3*CW];

    fps_ram #(
        .WIDTH (RAMW),
        .DEPTH (MAX_PORTALS)
    ) u_portal_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[SW-1:0]),
        .wdata ({in_right, in_left}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // side test: sign of acx*abz - acz*abx, four partial products
    pt_t xb, xc;
    logic signed [DW-1:0]  ma, mb;
    logic signed [PBW-1:0] mpart;
    logic signed [PW-1:0]  xmul;
    logic signed [AW-1:0]  xterm_w, xterm;
    logic xpos, xneg;

    always_comb
    begin
        xb = (tst_reg == T_R1 || tst_reg == T_L2) ? fr_reg : fl_reg;
        xc = (tst_reg == T_R1 || tst_reg == T_R2) ? nr_reg : nl_reg;
        ma = cs_reg[1] ? acz_reg : acx_reg;
        mb = cs_reg[1] ? abx_reg : abz_reg;
        if (cs_reg[0])
        begin
            mpart = PBW'($signed(mb[DW-1:LO]));
        end
        else
        begin
            mpart = $signed({1'b0, mb[LO-1:0]});
        end
        xmul    = ma * mpart;
        xterm_w = AW'(xmul);
        xterm   = cs_reg[0] ? (xterm_w <<< LO) : xterm_w;
    end

    assign xneg = acc_reg[AW-1];
    assign xpos = (acc_reg != '0) && !acc_reg[AW-1];

    // ------------------------------------------------------------------
    // corner blend: p + ((q-p)*r + half) >>> 16, one axis per cycle
    logic [RATIO_W-1:0]   ratio_c;
    logic signed [DW-1:0] bd;
    logic signed [BW-1:0] bmul, bt, bsh;
    logic [1:0]           bax;

    assign ratio_c = (ratio_reg > RATIO_ONE) ? RATIO_ONE : ratio_reg;
    assign bd      = DW'($signed(bq_reg[bs_reg])) - DW'($signed(bp_reg[bs_reg]));
    assign bmul    = bd * $signed({1'b0, ratio_c});
    assign bt      = bprod_reg + BW'(HALF_LSB);
    assign bsh     = bt >>> FRAC_BITS;
    assign bax     = bs_reg - 2'd1;

    // ------------------------------------------------------------------
    // decisions
    logic same_ar, same_al, out_free, emit_stall, store_ok, s_acc;
    logic r_upd, r_cross, r_to_r2, l1_skip, l_upd, l_cross, l_to_l2, r_go_l;
    logic out_push, out_last_set;

    assign same_ar  = (apex_reg == fr_reg);
    assign same_al  = (apex_reg == fl_reg);
    assign out_free = !out_valid_reg || m_tready;
    assign store_ok = (count_reg < CNTW'(MAX_PORTALS));
    assign s_acc    = s_tvalid && s_tready;
    assign emit_stall = (ocnt_reg < OUT_LIMIT) && pend_valid_reg && !out_free;

    assign r_upd   = (tst_reg == T_R1 && !xpos && same_ar) || (tst_reg == T_R2 && xpos);
    assign r_cross = (tst_reg == T_R2) && !xpos;
    assign r_to_r2 = (tst_reg == T_R1) && !xpos && !same_ar;
    assign r_go_l  = (tst_reg == T_R1 && xpos) || r_upd;
    assign l1_skip = (tst_reg == T_L1) && xneg;
    assign l_upd   = (tst_reg == T_L1 && !xneg && same_al) || (tst_reg == T_L2 && xneg);
    assign l_cross = (tst_reg == T_L2) && !xneg;
    assign l_to_l2 = (tst_reg == T_L1) && !xneg && !same_al;

    // ------------------------------------------------------------------
    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:   if (s_acc && s_tlast) state_next = ST_START;
            ST_START:  state_next = ST_INIT;
            ST_INIT:   state_next = ST_EMIT;
            ST_NEXT:   state_next = (scan_reg < count_reg) ? ST_FETCH : ST_GOAL;
            ST_FETCH:  state_next = ST_XSET;
            ST_XSET:   state_next = ST_XRUN;
            ST_XRUN:   if (cs_reg == 3'd4) state_next = ST_XDEC;
            ST_XDEC:
            begin
                if (r_cross || l_cross)
                begin
                    state_next = ST_BLEND;
                end
                else if (l1_skip || l_upd)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    state_next = ST_XSET;
                end
            end
            ST_BLEND:  if (bs_reg == 2'd3) state_next = ST_EMIT;
            ST_EMIT:   if (!emit_stall) state_next = ret_reg;
            ST_RST:    state_next = ST_REOPEN;
            ST_REOPEN: state_next = ST_NEXT;
            ST_GOAL:   state_next = (last_emit_reg != last_left_reg) ? ST_EMIT : ST_FIN;
            ST_FIN:    if (out_free) state_next = ST_LOAD;
            default:   state_next = ST_LOAD;
        endcase
    end

    // ------------------------------------------------------------------
    // state outputs
    always_comb
    begin
        s_tready     = 1'b0;
        ram_we       = 1'b0;
        ram_raddr    = scan_reg[SW-1:0];
        out_push     = 1'b0;
        out_last_set = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                ram_we   = s_tvalid && store_ok;
            end
            ST_START:  ram_raddr = '0;
            ST_RST:    ram_raddr = rs_reg;
            ST_EMIT:   out_push = !emit_stall && (ocnt_reg < OUT_LIMIT) && pend_valid_reg;
            ST_FIN:
            begin
                out_push     = out_free;
                out_last_set = 1'b1;
            end
            default:   ram_raddr = scan_reg[SW-1:0];
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            ret_reg        <= ST_LOAD;
            tst_reg        <= T_R1;
            count_reg      <= '0;
            scan_reg       <= '0;
            lslot_reg      <= '0;
            rslot_reg      <= '0;
            rs_reg         <= '0;
            ovf_reg        <= 1'b0;
            ratio_reg      <= '0;
            cs_reg         <= '0;
            bs_reg         <= '0;
            ocnt_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                ratio_reg <= cfg_wdata;
            end
            if (out_push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD:
                begin
                    if (s_acc)
                    begin
                        if (store_ok)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                    end
                end
                ST_INIT:
                begin
                    lslot_reg <= '0;
                    rslot_reg <= '0;
                    scan_reg  <= CNTW'(1);
                    ret_reg   <= ST_NEXT;
                end
                ST_FETCH:  tst_reg <= T_R1;
                ST_XSET:   cs_reg <= '0;
                ST_XRUN:   cs_reg <= cs_reg + 3'd1;
                ST_XDEC:
                begin
                    bs_reg <= '0;
                    if (r_go_l)
                    begin
                        tst_reg <= T_L1;
                    end
                    else if (r_to_r2)
                    begin
                        tst_reg <= T_R2;
                    end
                    else if (l_to_l2)
                    begin
                        tst_reg <= T_L2;
                    end
                    if (r_upd)
                    begin
                        rslot_reg <= scan_reg[SW-1:0];
                    end
                    if (l_upd)
                    begin
                        lslot_reg <= scan_reg[SW-1:0];
                    end
                    if (l1_skip || l_upd)
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                    if (r_cross)
                    begin
                        rs_reg  <= lslot_reg;
                        ret_reg <= ST_RST;
                    end
                    if (l_cross)
                    begin
                        rs_reg  <= rslot_reg;
                        ret_reg <= ST_RST;
                    end
                end
                ST_BLEND:  bs_reg <= bs_reg + 2'd1;
                ST_EMIT:
                begin
                    if (!emit_stall && (ocnt_reg < OUT_LIMIT))
                    begin
                        pend_valid_reg <= 1'b1;
                        ocnt_reg       <= ocnt_reg + 1'b1;
                    end
                end
                ST_RST:
                begin
                    lslot_reg <= rs_reg;
                    rslot_reg <= rs_reg;
                    scan_reg  <= CNTW'(rs_reg) + 1'b1;
                end
                ST_GOAL:   ret_reg <= ST_FIN;
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        count_reg      <= '0;
                        ovf_reg        <= 1'b0;
                        pend_valid_reg <= 1'b0;
                        ocnt_reg       <= '0;
                    end
                end
                default:   cs_reg <= cs_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            out_pt_reg   <= pend_reg;
            out_last_reg <= out_last_set;
            out_ovf_reg  <= ovf_reg;
        end
        case (state_reg)
            ST_LOAD:
            begin
                if (s_acc && store_ok)
                begin
                    last_left_reg <= in_left;
                end
            end
            ST_INIT:
            begin
                apex_reg    <= rd_left;
                fl_reg      <= rd_left;
                fr_reg      <= rd_right;
                fl_opp_reg  <= rd_right;
                fr_opp_reg  <= rd_left;
                emit_pt_reg <= rd_left;
            end
            ST_FETCH:
            begin
                nl_reg <= rd_left;
                nr_reg <= rd_right;
            end
            ST_XSET:
            begin
                abx_reg <= DW'($signed(xb[0])) - DW'($signed(apex_reg[0]));
                abz_reg <= DW'($signed(xb[2])) - DW'($signed(apex_reg[2]));
                acx_reg <= DW'($signed(xc[0])) - DW'($signed(apex_reg[0]));
                acz_reg <= DW'($signed(xc[2])) - DW'($signed(apex_reg[2]));
                acc_reg <= '0;
            end
            ST_XRUN:
            begin
                if (cs_reg != 3'd4)
                begin
                    xprod_reg <= xterm;
                    xsub_reg  <= cs_reg[1];
                end
                if (cs_reg != 3'd0)
                begin
                    acc_reg <= xsub_reg ? (acc_reg - xprod_reg) : (acc_reg + xprod_reg);
                end
            end
            ST_XDEC:
            begin
                if (r_upd)
                begin
                    fr_reg     <= nr_reg;
                    fr_opp_reg <= nl_reg;
                end
                if (l_upd)
                begin
                    fl_reg     <= nl_reg;
                    fl_opp_reg <= nr_reg;
                end
                if (r_cross)
                begin
                    bp_reg <= fl_reg;
                    bq_reg <= fl_opp_reg;
                end
                if (l_cross)
                begin
                    bp_reg <= fr_reg;
                    bq_reg <= fr_opp_reg;
                end
            end
            ST_BLEND:
            begin
                if (bs_reg != 2'd3)
                begin
                    bprod_reg <= bmul;
                end
                if (bs_reg != 2'd0)
                begin
                    emit_pt_reg[bax] <= bp_reg[bax] + bsh[CW-1:0];
                end
            end
            ST_EMIT:
            begin
                if (!emit_stall)
                begin
                    last_emit_reg <= emit_pt_reg;
                    if (ocnt_reg < OUT_LIMIT)
                    begin
                        pend_reg <= emit_pt_reg;
                    end
                end
            end
            ST_RST:
            begin
                apex_reg <= emit_pt_reg;
                fl_reg   <= emit_pt_reg;
                fr_reg   <= emit_pt_reg;
            end
            ST_REOPEN:
            begin
                fl_opp_reg <= rd_right;
                fr_opp_reg <= rd_left;
            end
            ST_GOAL:   emit_pt_reg <= last_left_reg;
            default:   ;
        endcase
    end

    // ------------------------------------------------------------------
    // master stream
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {FIELD_W'($signed(out_pt_reg[2])), FIELD_W'($signed(out_pt_reg[1])),
                       FIELD_W'($signed(out_pt_reg[0]))};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

endmodule

FILE: sv/fps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module fps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: verif/testbench.sv
// Testbench for the funnel path straightener: directed and random corridors
// checked against a behavioral funnel predictor.
`timescale 1ns / 1ps

module testbench
    import fps_pkg::*;
;

    localparam int STORE_DEPTH = 64;
    localparam int PATH_LIMIT  = 64;
    localparam int SIDE_LEFT   = -1;
    localparam int SIDE_ON     = 0;
    localparam int SIDE_RIGHT  = 1;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } point_t;

    typedef struct {
        point_t lpt;
        point_t rpt;
        logic   last_portal;
    } portal_t;

    typedef struct {
        point_t pt;
        logic   last_point;
        logic   overflow;
    } path_point_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [6*FIELD_W-1:0] s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [3*FIELD_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 cfg_we;
    logic [RATIO_W-1:0]   cfg_wdata;

    // predictor state
    portal_t     corridor_store[STORE_DEPTH];
    int          corridor_len;
    bit          corridor_overflow;
    logic [16:0] pull_ratio;
    path_point_t path_queue[$];

    int mismatch_count;
    int points_seen;
    bit hold_off;   // long receiver stall, set by the pressure test

    funnel_path_straightener_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------- predictor ----------------

    function automatic bit same_pt(point_t a, point_t b);
        return a.x == b.x && a.y == b.y && a.z == b.z;
    endfunction

    // Sign of the exact xz cross product; operands are 34-bit differences.
    function automatic int side_test(point_t a, point_t b, point_t c);
        logic signed [33:0]  abx, abz, acx, acz;
        logic signed [127:0] d;
        abx = 34'(signed'(b.x)) - 34'(signed'(a.x));
        abz = 34'(signed'(b.z)) - 34'(signed'(a.z));
        acx = 34'(signed'(c.x)) - 34'(signed'(a.x));
        acz = 34'(signed'(c.z)) - 34'(signed'(a.z));
        d = 128'(acx) * 128'(abz) - 128'(acz) * 128'(abx);
        if (d == 0)
            return SIDE_ON;
        return d < 0 ? SIDE_LEFT : SIDE_RIGHT;
    endfunction

    // Round half toward +inf of (p*(1-r) + q*r) / 2^16.
    function automatic logic signed [31:0] pull_axis(logic signed [31:0] p,
                                                    logic signed [31:0] q);
        logic signed [63:0] r, t;
        r = (pull_ratio > 17'h10000) ? 64'sd65536 : 64'(pull_ratio);
        t = 64'(p) * (64'sd65536 - r) + 64'(q) * r + 64'sd32768;
        return 32'(t >>> 16);
    endfunction

    function automatic point_t pull_corner(point_t p, point_t q);
        point_t o;
        o.x = pull_axis(p.x, q.x);
        o.y = pull_axis(p.y, q.y);
        o.z = pull_axis(p.z, q.z);
        return o;
    endfunction

    task automatic push_point(point_t p, inout point_t last_out, inout int cnt);
        path_point_t e;
        last_out = p;
        if (cnt >= PATH_LIMIT)
            return;
        e.pt = p;
        e.last_point = 1'b0;
        e.overflow = corridor_overflow;
        path_queue.push_back(e);
        cnt++;
    endtask

    task automatic straighten_corridor();
        point_t apex, fl, fr, nl, nr, c, last_out;
        int     n, ls, rs, s, cnt;
        n = corridor_len;
        cnt = 0;
        last_out = '{0, 0, 0};
        apex = corridor_store[0].lpt;
        fl = apex;
        fr = corridor_store[0].rpt;
        ls = 0;
        rs = 0;
        push_point(apex, last_out, cnt);
        s = 1;
        while (s < n)
        begin
            nl = corridor_store[s].lpt;
            nr = corridor_store[s].rpt;
            if (side_test(apex, fr, nr) != SIDE_RIGHT)
            begin
                if (same_pt(apex, fr) || side_test(apex, fl, nr) == SIDE_RIGHT)
                begin
                    fr = nr;
                    rs = s;
                end
                else
                begin
                    c = pull_corner(fl, corridor_store[ls].rpt);
                    push_point(c, last_out, cnt);
                    apex = c; fl = c; fr = c; rs = ls; s = ls + 1;
                    continue;
                end
            end
            if (side_test(apex, fl, nl) != SIDE_LEFT)
            begin
                if (same_pt(apex, fl) || side_test(apex, fr, nl) == SIDE_LEFT)
                begin
                    fl = nl;
                    ls = s;
                end
                else
                begin
                    c = pull_corner(fr, corridor_store[rs].lpt);
                    push_point(c, last_out, cnt);
                    apex = c; fl = c; fr = c; ls = rs; s = rs + 1;
                    continue;
                end
            end
            s++;
        end
        if (!same_pt(last_out, corridor_store[n-1].lpt))
            push_point(corridor_store[n-1].lpt, last_out, cnt);
        if (cnt > 0)
            path_queue[path_queue.size()-1].last_point = 1'b1;
    endtask

    task automatic predict_portal(portal_t p);
        if (corridor_len < STORE_DEPTH)
        begin
            corridor_store[corridor_len] = p;
            corridor_len++;
        end
        else
            corridor_overflow = 1'b1;
        if (p.last_portal)
        begin
            straighten_corridor();
            corridor_len = 0;
            corridor_overflow = 1'b0;
        end
    endtask

    // ---------------- drivers ----------------

    function automatic int random_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40)
            return 0;
        if (k < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sends one portal; the prediction is made at acceptance.
    task automatic send_portal(portal_t p, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : random_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p.rpt.z, p.rpt.y, p.rpt.x, p.lpt.z, p.lpt.y, p.lpt.x};
        s_tlast  <= p.last_portal;
        do
            @(posedge clk);
        while (!s_tready);
        predict_portal(p);
    endtask

    task automatic stream_idle();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_path_done();
        while (path_queue.size() != 0)
            @(posedge clk);
        // portals without results may still be busy; let the block settle
        repeat (50) @(posedge clk);
    endtask

    task automatic write_ratio(logic [16:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pull_ratio = v;
    endtask

    function automatic point_t rand_point(int span);
        point_t p;
        if (span == 0)
        begin
            p.x = $urandom;
            p.y = $urandom;
            p.z = $urandom;
        end
        else
        begin
            p.x = $urandom_range(0, 2*span) - span;
            p.y = $urandom;
            p.z = $urandom_range(0, 2*span) - span;
        end
        return p;
    endfunction

    // Well-formed corridor: start, widening/narrowing portals walking +z
    // with random lateral drift, goal. span 0 gives raw full-range noise.
    task automatic send_corridor(int len, int span, bit no_gap = 0);
        portal_t p;
        int      cx, cz, w;
        cx = 0;
        cz = 0;
        for (int i = 0; i < len; i++)
        begin
            if (span == 0)
            begin
                p.lpt = rand_point(0);
                p.rpt = rand_point(0);
            end
            else
            begin
                cx += $urandom_range(0, 2*span) - span;
                cz += $urandom_range(span/4, span);
                w  = $urandom_range(1, span);
                p.lpt = '{cx - w, $urandom, cz + $urandom_range(0, 3)};
                p.rpt = '{cx + w, $urandom, cz};
            end
            if (i == 0 || i == len - 1)
                p.rpt = p.lpt;
            p.last_portal = (i == len - 1);
            send_portal(p, no_gap);
        end
        stream_idle();
    endtask

    // ---------------- checker ----------------

    always @(posedge clk)
    begin
        path_point_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            points_seen++;
            if (path_queue.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected path point %h", m_tdata);
            end
            else
            begin
                e = path_queue.pop_front();
                if (m_tdata[31:0] !== e.pt.x || m_tdata[63:32] !== e.pt.y
                    || m_tdata[95:64] !== e.pt.z || m_tlast !== e.last_point
                    || m_tuser !== e.overflow)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("path mismatch: exp x=%h y=%h z=%h l=%b o=%b / got %h l=%b o=%b",
                                 e.pt.x, e.pt.y, e.pt.z, e.last_point, e.overflow,
                                 m_tdata, m_tlast, m_tuser);
                end
            end
        end
    end

    // Receiver stall pattern: random gaps, or a long hold-off on request.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 9) == 0);
    end

    // ---------------- tests ----------------

    task automatic test_extremes();
        portal_t p;
        point_t  hi, lo;
        hi = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
        lo = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
        // single-portal path: start equals goal
        p = '{hi, hi, 1'b1};
        send_portal(p);
        // extremes of both signs, crossing sides
        p = '{lo, lo, 1'b0}; send_portal(p);
        p = '{hi, lo, 1'b0}; send_portal(p);
        p = '{lo, hi, 1'b0}; send_portal(p);
        p = '{'{0, 5, 32'sh7fffffff}, '{32'sh7fffffff, -5, 0}, 1'b0}; send_portal(p);
        p = '{hi, hi, 1'b1}; send_portal(p);
        // collinear portals, degenerate funnel sides
        p = '{'{0, 0, 0}, '{0, 0, 0}, 1'b0}; send_portal(p);
        p = '{'{0, 1, 100}, '{0, 2, 100}, 1'b0}; send_portal(p);
        p = '{'{0, 3, 200}, '{0, 4, 200}, 1'b0}; send_portal(p);
        p = '{'{0, 0, 0}, '{0, 0, 0}, 1'b1}; send_portal(p);
        stream_idle();
        wait_path_done();
    endtask

    task automatic test_corners(logic [16:0] ratio);
        write_ratio(ratio);
        // two random corridors with lateral drift, to exercise corners on both sides
        for (int k = 0; k < 2; k++)
            send_corridor($urandom_range(4, 12), 1 << $urandom_range(4, 20));
        wait_path_done();
    endtask

    task automatic test_random(int items);
        int sent, len;
        sent = 0;
        while (sent < items)
        begin
            len = $urandom_range(0, 9) == 0 ? $urandom_range(30, 70) : $urandom_range(2, 10);
            send_corridor(len, $urandom_range(0, 7) == 0 ? 0 : 1 << $urandom_range(3, 24));
            sent += len;
        end
        wait_path_done();
    endtask

    task automatic test_overflow();
        send_corridor(STORE_DEPTH + 3, 4096);
        send_corridor(STORE_DEPTH + 1, 0);   // goal dropped, store full
        wait_path_done();
    endtask

    // Receiver stalls long enough that hold and output stages fill and the
    // scan, then the input, back up.
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                send_corridor(20, 1 << 12, 1);
                send_corridor(12, 1 << 12, 1);
            end
        join
        wait_path_done();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        hold_off = 1'b0;
        pull_ratio = '0;
        corridor_len = 0;
        corridor_overflow = 1'b0;
        mismatch_count = 0;
        points_seen = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_corners(17'h00000);
        test_corners(17'h10000);
        test_corners(17'h1ffff);   // above one clamps to one
        test_corners(17'h08000);
        test_overflow();
        test_backpressure();
        write_ratio(17'($urandom_range(0, 17'h1ffff)));
        test_random(15);
        write_ratio(17'($urandom_range(0, 17'h10000)));
        test_random(15);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule
